[src/lda_pkg.sv]
package lda_pkg;

    localparam int COORD_FRAC_BITS = 24;
    localparam int COEF_FRAC_BITS  = 28;

    // align coefficient to coordinate format
    localparam int CONV_LSH = (COORD_FRAC_BITS > COEF_FRAC_BITS) ?
                              (COORD_FRAC_BITS - COEF_FRAC_BITS) : 0;
    localparam int CONV_RSH = (COEF_FRAC_BITS > COORD_FRAC_BITS) ?
                              (COEF_FRAC_BITS - COORD_FRAC_BITS) : 0;

    localparam logic signed [63:0] LIM62     = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic        [61:0] LIM62_MAG = 62'h3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        REG_K1, REG_K2, REG_K3, REG_TAN, REG_D0, REG_D1, REG_D2, REG_MODE
    } reg_idx_t;

    localparam logic [2:0] DM_SCALED   = 3'd1;
    localparam logic [2:0] DM_RADIAL_Z = 3'd2;
    localparam logic [2:0] DM_OFFSET   = 3'd3;
    localparam logic [2:0] DM_LINEAR   = 3'd4;
    localparam logic [2:0] DM_AFFINE   = 3'd5;
    localparam logic [2:0] DM_QUAD     = 3'd6;

    // value in flight with its sticky clamp flag
    typedef struct packed {
        logic               f;
        logic signed [63:0] v;
    } val_t;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pt_t;

    typedef struct packed {
        logic               f;
        logic signed [31:0] v;
    } res32_t;

    function automatic val_t from32(logic signed [31:0] d);
        val_t r;
        r.f = 1'b0;
        r.v = 64'(d);
        return r;
    endfunction

    function automatic val_t conv_coef(logic signed [31:0] d);
        val_t r;
        r.f = 1'b0;
        r.v = (64'(d) <<< CONV_LSH) >>> CONV_RSH;
        return r;
    endfunction

    function automatic val_t sadd(val_t a, val_t b);
        val_t               r;
        logic signed [63:0] s;
        s   = a.v + b.v;
        r.f = a.f | b.f;
        r.v = s;
        if (s > LIM62) begin
            r.v = LIM62;
            r.f = 1'b1;
        end else if (s < -LIM62) begin
            r.v = -LIM62;
            r.f = 1'b1;
        end
        return r;
    endfunction

    function automatic res32_t sat32(val_t a);
        res32_t r;
        r.f = a.f;
        r.v = a.v[31:0];
        if (a.v > 64'sh0000_0000_7FFF_FFFF) begin
            r.v = 32'sh7FFF_FFFF;
            r.f = 1'b1;
        end else if (a.v < -64'sh0000_0000_8000_0000) begin
            r.v = 32'sh8000_0000;
            r.f = 1'b1;
        end
        return r;
    endfunction

endpackage

[src/lda_fmul.sv]
module lda_fmul #(
    parameter int SH = 24
) (
    input  logic          aclk,
    input  logic          ce,
    input  lda_pkg::val_t a,
    input  lda_pkg::val_t b,
    output lda_pkg::val_t p
);
    import lda_pkg::*;

    localparam int PW = 124;
    localparam int QW = PW - SH;

    logic [63:0]  ua, ub;
    logic         neg1_reg, f1_reg;
    logic [61:0]  ma1_reg, mb1_reg;

    logic         neg2_reg, f2_reg;
    logic [63:0]  p00_reg;
    logic [61:0]  p01_reg, p10_reg;
    logic [59:0]  p11_reg;

    logic         neg3_reg, f3_reg;
    logic [62:0]  mid;
    logic [95:0]  lo3_reg;
    logic [59:0]  hi3_reg;

    logic         neg4_reg, f4_reg, rem4_reg;
    logic [PW-1:0] prod;
    logic [QW-1:0] q4_reg;

    logic         neg5_reg, f5_reg, sat5_reg;
    logic [QW:0]  qi;
    logic [61:0]  mag5_reg;

    val_t         p_reg;

    always_comb begin
        ua   = a.v[63] ? 64'(-a.v) : 64'(a.v);
        ub   = b.v[63] ? 64'(-b.v) : 64'(b.v);
        mid  = {1'b0, p01_reg} + {1'b0, p10_reg};
        prod = {hi3_reg, 64'h0} + PW'(lo3_reg);
        qi   = {1'b0, q4_reg} + (QW+1)'(neg4_reg & rem4_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            neg1_reg <= a.v[63] ^ b.v[63];
            f1_reg   <= a.f | b.f;
            ma1_reg  <= ua[61:0];
            mb1_reg  <= ub[61:0];

            neg2_reg <= neg1_reg;
            f2_reg   <= f1_reg;
            p00_reg  <= 64'(ma1_reg[31:0]) * 64'(mb1_reg[31:0]);
            p01_reg  <= 62'(64'(ma1_reg[31:0]) * 64'(mb1_reg[61:32]));
            p10_reg  <= 62'(64'(ma1_reg[61:32]) * 64'(mb1_reg[31:0]));
            p11_reg  <= 60'(64'(ma1_reg[61:32]) * 64'(mb1_reg[61:32]));

            neg3_reg <= neg2_reg;
            f3_reg   <= f2_reg;
            lo3_reg  <= 96'({mid, 32'h0}) + 96'(p00_reg);
            hi3_reg  <= p11_reg;

            neg4_reg <= neg3_reg;
            f4_reg   <= f3_reg;
            q4_reg   <= prod[PW-1:SH];
            rem4_reg <= |prod[SH-1:0];

            neg5_reg <= neg4_reg;
            f5_reg   <= f4_reg;
            sat5_reg <= qi > (QW+1)'(LIM62_MAG);
            mag5_reg <= qi[61:0];

            p_reg.f  <= f5_reg | sat5_reg;
            if (sat5_reg) begin
                p_reg.v <= neg5_reg ? -LIM62 : LIM62;
            end else begin
                p_reg.v <= neg5_reg ? -$signed({2'b00, mag5_reg}) : $signed({2'b00, mag5_reg});
            end
        end
    end

    assign p = p_reg;

endmodule

[src/lens_distortion_apply_core.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: x_in, y_in, z_in
// m_        out        m_tvalid/m_tready  m_tdata: x_out, y_out, z_out; m_tuser: saturated
// apb       in         psel/penable       paddr, pwdata, prdata
//
// One item per cycle while the output is taken; pipeline depth is set by the
// chain of dependent 64-bit multiplies (r2, r4, r6, k3 term, radial scale),
// each a six-stage unit of four 32x32 partial products.
// Reset clears valid bits and configuration registers. When the output register
// holds an item that is not taken, the whole pipeline holds and s_tready drops.
module lens_distortion_apply_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_in, y_in, z_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // x_out, y_out, z_out
    output logic [0:0]  m_tuser,   // saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import lda_pkg::*;

    logic signed [31:0] k1_reg, k2_reg, k3_reg, d0_reg, d1_reg, d2_reg;
    logic        [63:0] tan_reg;
    logic        [2:0]  mode_reg;
    reg_idx_t           widx;

    logic ce;
    logic [34:0] vld_reg;
    logic        m_valid_reg;
    pt_t         pt_reg [34];

    val_t k1v, k2v, k3v, p1v, p2v, d0v, d1v, d2v, one, cd0, cd1, cd2, zero;

    val_t xx, yy, xy, zz, d0z, d1z, zzz, d0zz, r4, c1, zr2, d1r2, p2xy, p1xy;
    val_t txa, tya, d1z3, r6, c2, d2r4, d0zr2, c3, dz1, dxr, dyr;

    val_t r2_reg, xy2_reg, xx2_reg, yy2_reg, opd_reg, r2x_reg, r2y_reg;
    val_t t6a_reg, dxt_reg, dyt_reg, c12_reg, s1_reg, poly_reg;
    val_t sx_reg, sy_reg, xs_reg, ys_reg, zs_reg;
    val_t p2xy_dly_reg, p1xy_dly_reg, d1z3_dly_reg;
    val_t r2_dly_reg   [6];
    val_t d1z_dly_reg  [6];
    val_t c1_dly_reg   [6];
    val_t d1r2_dly_reg [6];
    val_t opd_dly_reg  [13];
    val_t c12_dly_reg  [5];
    val_t dxt_dly_reg  [18];
    val_t dyt_dly_reg  [18];
    val_t dzc_reg      [7:33];
    val_t dz_first;

    res32_t xo, yo, zo;
    logic signed [31:0] xo_reg, yo_reg, zo_reg;
    logic               sat_reg;

    // configuration
    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_reg   <= '0;
            k2_reg   <= '0;
            k3_reg   <= '0;
            tan_reg  <= '0;
            d0_reg   <= '0;
            d1_reg   <= '0;
            d2_reg   <= '0;
            mode_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                REG_K1:   k1_reg   <= pwdata[31:0];
                REG_K2:   k2_reg   <= pwdata[31:0];
                REG_K3:   k3_reg   <= pwdata[31:0];
                REG_TAN:  tan_reg  <= pwdata;
                REG_D0:   d0_reg   <= pwdata[31:0];
                REG_D1:   d1_reg   <= pwdata[31:0];
                REG_D2:   d2_reg   <= pwdata[31:0];
                REG_MODE: mode_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_K1:   prdata = 64'(unsigned'(k1_reg));
            REG_K2:   prdata = 64'(unsigned'(k2_reg));
            REG_K3:   prdata = 64'(unsigned'(k3_reg));
            REG_TAN:  prdata = tan_reg;
            REG_D0:   prdata = 64'(unsigned'(d0_reg));
            REG_D1:   prdata = 64'(unsigned'(d1_reg));
            REG_D2:   prdata = 64'(unsigned'(d2_reg));
            REG_MODE: prdata = 64'(mode_reg);
            default:  prdata = '0;
        endcase
    end

    always_comb begin
        k1v   = from32(k1_reg);
        k2v   = from32(k2_reg);
        k3v   = from32(k3_reg);
        p1v   = from32(tan_reg[31:0]);
        p2v   = from32(tan_reg[63:32]);
        d0v   = from32(d0_reg);
        d1v   = from32(d1_reg);
        d2v   = from32(d2_reg);
        cd0   = conv_coef(d0_reg);
        cd1   = conv_coef(d1_reg);
        cd2   = conv_coef(d2_reg);
        zero  = '0;
        one.f = 1'b0;
        one.v = 64'sd1 <<< COORD_FRAC_BITS;
    end

    // handshake
    assign ce       = !m_valid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg     <= {vld_reg[33:0], s_tvalid};
            m_valid_reg <= vld_reg[34];
        end
    end

    // multipliers, stage in -> stage out
    lda_fmul #(.SH(COORD_FRAC_BITS)) u_xx (aclk, ce, from32(pt_reg[0].x), from32(pt_reg[0].x), xx);
    lda_fmul #(.SH(COORD_FRAC_BITS)) u_yy (aclk, ce, from32(pt_reg[0].y), from32(pt_reg[0].y), yy);
    lda_fmul #(.SH(COORD_FRAC_BITS)) u_xy (aclk, ce, from32(pt_reg[0].x), from32(pt_reg[0].y), xy);
    lda_fmul #(.SH(COORD_FRAC_BITS)) u_zz (aclk, ce, from32(pt_reg[0].z), from32(pt_reg[0].z), zz);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_d0z (aclk, ce, d0v, from32(pt_reg[0].z), d0z);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_d1z (aclk, ce, d1v, from32(pt_reg[0].z), d1z);

    lda_fmul #(.SH(COORD_FRAC_BITS)) u_zzz  (aclk, ce, zz, from32(pt_reg[6].z), zzz);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_d0zz (aclk, ce, d0v, zz, d0zz);

    lda_fmul #(.SH(COORD_FRAC_BITS)) u_r4   (aclk, ce, r2_reg, r2_reg, r4);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_c1   (aclk, ce, k1v, r2_reg, c1);
    lda_fmul #(.SH(COORD_FRAC_BITS)) u_zr2  (aclk, ce, from32(pt_reg[7].z), r2_reg, zr2);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_d1r2 (aclk, ce, d1v, r2_reg, d1r2);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_p2xy (aclk, ce, p2v, xy2_reg, p2xy);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_p1xy (aclk, ce, p1v, xy2_reg, p1xy);

    lda_fmul #(.SH(COEF_FRAC_BITS))  u_txa  (aclk, ce, p1v, r2x_reg, txa);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_tya  (aclk, ce, p2v, r2y_reg, tya);

    lda_fmul #(.SH(COEF_FRAC_BITS))  u_d1z3 (aclk, ce, d1v, zzz, d1z3);

    lda_fmul #(.SH(COORD_FRAC_BITS)) u_r6    (aclk, ce, r4, r2_dly_reg[5], r6);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_c2    (aclk, ce, k2v, r4, c2);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_d2r4  (aclk, ce, d2v, r4, d2r4);
    lda_fmul #(.SH(COEF_FRAC_BITS))  u_d0zr2 (aclk, ce, d0v, zr2, d0zr2);

    lda_fmul #(.SH(COEF_FRAC_BITS))  u_c3  (aclk, ce, k3v, r6, c3);
    lda_fmul #(.SH(COORD_FRAC_BITS)) u_dz1 (aclk, ce, opd_dly_reg[12], s1_reg, dz1);

    lda_fmul #(.SH(COORD_FRAC_BITS)) u_dxr (aclk, ce, from32(pt_reg[26].x), poly_reg, dxr);
    lda_fmul #(.SH(COORD_FRAC_BITS)) u_dyr (aclk, ce, from32(pt_reg[26].y), poly_reg, dyr);

    // cheap depth models, picked at stage 6
    always_comb begin
        case (mode_reg)
            DM_OFFSET: dz_first = cd0;
            DM_LINEAR: dz_first = d0z;
            DM_AFFINE: dz_first = sadd(d0z, cd1);
            default:   dz_first = zero;
        endcase
    end

    always_comb begin
        xo = sat32(xs_reg);
        yo = sat32(ys_reg);
        zo = sat32(zs_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pt_reg[0] <= s_tdata;
            for (int i = 1; i < 34; i++) begin
                pt_reg[i] <= pt_reg[i-1];
            end

            // stage 7
            r2_reg  <= sadd(xx, yy);
            xy2_reg <= sadd(xy, xy);
            xx2_reg <= sadd(xx, xx);
            yy2_reg <= sadd(yy, yy);
            opd_reg <= sadd(one, d0z);
            // stage 8
            r2x_reg <= sadd(r2_reg, xx2_reg);
            r2y_reg <= sadd(r2_reg, yy2_reg);
            // stage 13
            t6a_reg <= sadd(d0zz, d1z_dly_reg[5]);
            // stage 14, 15
            p2xy_dly_reg <= p2xy;
            p1xy_dly_reg <= p1xy;
            dxt_reg <= sadd(txa, p2xy_dly_reg);
            dyt_reg <= sadd(tya, p1xy_dly_reg);
            // stage 19, 20
            d1z3_dly_reg <= d1z3;
            c12_reg <= sadd(c1_dly_reg[5], c2);
            s1_reg  <= sadd(d1r2_dly_reg[5], d2r4);
            // stage 26
            poly_reg <= sadd(c12_dly_reg[4], c3);
            // stage 33, 34
            sx_reg <= sadd(from32(pt_reg[32].x), dxr);
            sy_reg <= sadd(from32(pt_reg[32].y), dyr);
            xs_reg <= sadd(sx_reg, dxt_dly_reg[17]);
            ys_reg <= sadd(sy_reg, dyt_dly_reg[17]);
            zs_reg <= sadd(from32(pt_reg[33].z), dzc_reg[33]);
            // stage 35
            xo_reg  <= xo.v;
            yo_reg  <= yo.v;
            zo_reg  <= zo.v;
            sat_reg <= xo.f | yo.f | zo.f;

            r2_dly_reg[0]   <= r2_reg;
            d1z_dly_reg[0]  <= d1z;
            c1_dly_reg[0]   <= c1;
            d1r2_dly_reg[0] <= d1r2;
            for (int i = 1; i < 6; i++) begin
                r2_dly_reg[i]   <= r2_dly_reg[i-1];
                d1z_dly_reg[i]  <= d1z_dly_reg[i-1];
                c1_dly_reg[i]   <= c1_dly_reg[i-1];
                d1r2_dly_reg[i] <= d1r2_dly_reg[i-1];
            end
            opd_dly_reg[0] <= opd_reg;
            for (int i = 1; i < 13; i++) begin
                opd_dly_reg[i] <= opd_dly_reg[i-1];
            end
            c12_dly_reg[0] <= c12_reg;
            for (int i = 1; i < 5; i++) begin
                c12_dly_reg[i] <= c12_dly_reg[i-1];
            end
            dxt_dly_reg[0] <= dxt_reg;
            dyt_dly_reg[0] <= dyt_reg;
            for (int i = 1; i < 18; i++) begin
                dxt_dly_reg[i] <= dxt_dly_reg[i-1];
                dyt_dly_reg[i] <= dyt_dly_reg[i-1];
            end

            // depth delta rides along, replaced where its model finishes
            dzc_reg[7] <= dz_first;
            for (int k = 8; k < 34; k++) begin
                if (k == 14 && mode_reg == DM_QUAD) begin
                    dzc_reg[k] <= sadd(t6a_reg, cd2);
                end else if (k == 20 && mode_reg == DM_RADIAL_Z) begin
                    dzc_reg[k] <= sadd(d0zr2, d1z3_dly_reg);
                end else if (k == 27 && mode_reg == DM_SCALED) begin
                    dzc_reg[k] <= dz1;
                end else begin
                    dzc_reg[k] <= dzc_reg[k-1];
                end
            end
        end
    end

    assign m_tdata = {zo_reg, yo_reg, xo_reg};
    assign m_tuser = sat_reg;

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item missing at stage 0");

    a_last_stage_feeds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[34] && ce |=> m_valid_reg)
        else $error("item lost at output register");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && vld_reg == '0)
        else $error("pipeline not empty after reset");
`endif

endmodule

[tb/sv/tb_lens_distortion_apply_core.sv]
module tb_lens_distortion_apply_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lda_pkg::*;

    localparam logic [2:0] DM_NONE   = 3'd0;
    localparam logic [2:0] DM_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } distorted_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;    // x_in, y_in, z_in
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;    // x_out, y_out, z_out
    logic [0:0]  m_tuser;    // saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    lens_distortion_apply_core u_top (.*);

    // shadow copy of the coefficient registers
    logic signed [31:0] k1, k2, k3, p1, p2, d0, d1, d2;
    logic [2:0]         depth_mode;
    logic               clamp_seen;

    distorted_t expected_points[$];
    int  errors;
    bit  steady;      // no idling on either side
    int  quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic signed [63:0] clamp62(logic signed [127:0] v);
        if (v > 128'(LIM62)) begin
            clamp_seen = 1'b1;
            return LIM62;
        end
        if (v < -128'(LIM62)) begin
            clamp_seen = 1'b1;
            return -LIM62;
        end
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] add_q(logic signed [63:0] a, logic signed [63:0] b);
        return clamp62(128'(a) + 128'(b));
    endfunction

    function automatic logic signed [63:0] mul_shift(logic signed [63:0] a,
                                                     logic signed [63:0] b, int sh);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clamp62(p >>> sh);
    endfunction

    function automatic logic signed [63:0] qm(logic signed [63:0] a, logic signed [63:0] b);
        return mul_shift(a, b, COORD_FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] cm(logic signed [31:0] c, logic signed [63:0] v);
        return mul_shift(64'(c), v, COEF_FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] to32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            clamp_seen = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            clamp_seen = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic distorted_t distort_point(pt_t pt);
        logic signed [63:0] x, y, z, one, xx, yy, r2, r4, r6, poly, xy2, dxt, dyt, dz;
        distorted_t r;
        clamp_seen = 1'b0;
        x = 64'(pt.x);
        y = 64'(pt.y);
        z = 64'(pt.z);
        one = 64'sd1 <<< COORD_FRAC_BITS;
        xx = qm(x, x);
        yy = qm(y, y);
        r2 = add_q(xx, yy);
        r4 = qm(r2, r2);
        r6 = qm(r4, r2);
        poly = add_q(add_q(cm(k1, r2), cm(k2, r4)), cm(k3, r6));
        xy2 = add_q(qm(x, y), qm(x, y));
        dxt = add_q(cm(p1, add_q(r2, add_q(xx, xx))), cm(p2, xy2));
        dyt = add_q(cm(p2, add_q(r2, add_q(yy, yy))), cm(p1, xy2));
        case (depth_mode)
            DM_SCALED:   dz = qm(add_q(one, cm(d0, z)), add_q(cm(d1, r2), cm(d2, r4)));
            DM_RADIAL_Z: dz = add_q(cm(d0, qm(z, r2)), cm(d1, qm(qm(z, z), z)));
            DM_OFFSET:   dz = cm(d0, one);
            DM_LINEAR:   dz = cm(d0, z);
            DM_AFFINE:   dz = add_q(cm(d0, z), cm(d1, one));
            DM_QUAD:     dz = add_q(add_q(cm(d0, qm(z, z)), cm(d1, z)), cm(d2, one));
            default:     dz = 64'sd0;
        endcase
        r.x = to32(add_q(add_q(x, qm(x, poly)), dxt));
        r.y = to32(add_q(add_q(y, qm(y, poly)), dyt));
        r.z = to32(add_q(z, dz));
        r.sat = clamp_seen;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        distorted_t exp_pt, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata};
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected item %h", $time, got);
                errors++;
            end else begin
                exp_pt = expected_points.pop_front();
                if (got.x !== exp_pt.x) begin
                    $display("%0t: x_out expected %h actual %h", $time, exp_pt.x, got.x);
                    errors++;
                end
                if (got.y !== exp_pt.y) begin
                    $display("%0t: y_out expected %h actual %h", $time, exp_pt.y, got.y);
                    errors++;
                end
                if (got.z !== exp_pt.z) begin
                    $display("%0t: z_out expected %h actual %h", $time, exp_pt.z, got.z);
                    errors++;
                end
                if (got.sat !== exp_pt.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, exp_pt.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_K1:   k1 = value[31:0];
            REG_K2:   k2 = value[31:0];
            REG_K3:   k3 = value[31:0];
            REG_TAN:  {p2, p1} = value;
            REG_D0:   d0 = value[31:0];
            REG_D1:   d1 = value[31:0];
            REG_D2:   d2 = value[31:0];
            REG_MODE: depth_mode = value[2:0];
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [63:0] tan, logic [31:0] e0, logic [31:0] e1,
                             logic [31:0] e2, logic [2:0] mode);
        drain();
        write_reg(REG_K1, 64'(a));
        write_reg(REG_K2, 64'(b));
        write_reg(REG_K3, 64'(c));
        write_reg(REG_TAN, tan);
        write_reg(REG_D0, 64'(e0));
        write_reg(REG_D1, 64'(e1));
        write_reg(REG_D2, 64'(e2));
        write_reg(REG_MODE, 64'(mode));
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pt_t pt;
        pt = {z, y, x};
        if (!steady && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_points.push_back(distort_point(pt));
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
            2: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            default: return 32'h0;
        endcase
    endfunction

    task automatic test_identity();
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000);
    endtask

    task automatic test_radial_tangential();
        set_coefs(32'h0400_0000, 32'hFE00_0000, 32'h0080_0000,
                  {32'hFF80_0000, 32'h0040_0000}, 0, 0, 0, DM_NONE);
        send_point(32'h0080_0000, 32'h0040_0000, 32'h0);
        send_point(32'hFF30_0000, 32'h00C0_0000, 32'h1);
        // big radius: internal clamp even where output may end in range
        set_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  {32'h8000_0000, 32'h7FFF_FFFF}, 0, 0, 0, DM_NONE);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send_point(32'h8000_0000, 32'h0000_0001, 32'h0);
        send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
    endtask

    task automatic test_depth_modes();
        for (int m = 0; m < 8; m++) begin
            set_coefs(32'h0100_0000, 0, 0, 64'h0, 32'h0800_0000, 32'hF800_0000,
                      32'h1234_5678, 3'(m));
            send_point(32'h0080_0000, 32'hFF80_0000, 32'h0200_0000);
            send_point(32'h0010_0000, 32'h0, 32'h8000_0000);
        end
        set_coefs(0, 0, 0, 64'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, DM_QUAD);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            steady = (phase == 3);
            if (phase == 7) begin
                set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, DM_UNUSED);
            end else begin
                set_coefs(rand_word() >>> $urandom_range(8), rand_word() >>> $urandom_range(8),
                          rand_word() >>> $urandom_range(12), {rand_word(), rand_word()},
                          rand_word(), rand_word(), rand_word(), 3'($urandom_range(7)));
            end
            for (int i = 0; i < 90; i++) begin
                send_point(rand_word(), rand_word(), rand_word());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        {k1, k2, k3, p1, p2, d0, d1, d2} = '0;
        depth_mode   = DM_NONE;
        steady       = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_identity();
        test_radial_tangential();
        test_depth_modes();
        test_random();
        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
